FILE: design/rmu_pkg.sv
package rmu_pkg;

  // Field widths
  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = 33;
  localparam int COUNT_W  = 9;

  // Packed widths of the stream ports
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 48;

  // Control sequencer states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WAIT
  } rmu_state_t;

endpackage

FILE: design/rmu_cell.sv
module rmu_cell #(
  parameter int IDX_W = 8,
  parameter int CNT_W = 9,
  parameter int INDEX = 0
) (
  input  logic                                clk,
  input  logic                                load,
  input  logic signed [rmu_pkg::SAMPLE_W-1:0] x,
  input  logic [CNT_W-1:0]                    fill,
  input  logic                                left_gt,
  input  logic signed [rmu_pkg::SAMPLE_W-1:0] left_value,
  input  logic [IDX_W-1:0]                    lo_idx,
  input  logic [IDX_W-1:0]                    hi_idx,
  output logic                                gt,
  output logic signed [rmu_pkg::SAMPLE_W-1:0] value,
  output logic [2*rmu_pkg::SAMPLE_W-1:0]      leaf
);
  import rmu_pkg::*;

  logic held;

  // Entry is live when its position is below the fill level
  assign held = CNT_W'(INDEX) < fill;
  assign gt   = held && (value > x);

  // Insert step: shift from the left, take the sample, or keep
  always_ff @(posedge clk) begin
    if (load) begin
      if (left_gt) begin
        value <= left_value;
      end else if (gt || !held) begin
        value <= x;
      end
    end
  end

  // Offer the value to the median read-out when selected
  assign leaf[SAMPLE_W-1:0]          = (lo_idx == IDX_W'(INDEX)) ? value : '0;
  assign leaf[2*SAMPLE_W-1:SAMPLE_W] = (hi_idx == IDX_W'(INDEX)) ? value : '0;

endmodule

FILE: design/rmu_or_tree.sv
module rmu_or_tree #(
  parameter int LEAVES = 256,
  parameter int WIDTH  = 64
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] leaf [LEAVES],
  output logic [WIDTH-1:0] root
);
  import rmu_pkg::*;

  localparam int LEVELS = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int PADDED = 2 ** LEVELS;
  localparam int NODES  = 2 * PADDED - 1;

  // Heap-ordered nodes: leaves at the back, root at entry zero
  logic [WIDTH-1:0] node [NODES];

  // Every node registered; one tree level per cycle
  always_ff @(posedge clk) begin
    for (int n = 0; n < PADDED - 1; n++) begin
      node[n] <= node[2*n+1] | node[2*n+2];
    end
    for (int k = 0; k < PADDED; k++) begin
      node[PADDED-1+k] <= (k < LEAVES) ? leaf[k] : '0;
    end
  end

  assign root = node[0];

endmodule

FILE: design/running_median_unit.sv
// Running median of a stream of signed 32-bit samples.
// Input channel s_*: one sample per transfer in s_tdata, s_tuser flags a clear
// that empties the store before the sample goes in. Output channel m_*: one
// result per input transfer with twice the median (sum of the two middle
// values for an even count), the number of samples held and an overflow flag.
// Samples sit in a row of cells kept in ascending order; on an insert every
// cell compares against the new sample and the larger entries shift right.
// The two middle entries are then collected by a registered OR tree of
// log2(CAPACITY) levels, whose depth sets how long the unit waits for the
// result. A new sample is taken only once the last result has gone into the
// output register. A full store drops the sample, raises overflow and
// reports the unchanged median.
// A result waits in the output register while m_tready is low; the next
// sample is still taken in, and its result is held back until the register
// frees. Reset empties the store, clears the output valid and holds s_tready
// low; no sweep is needed.
module running_median_unit #(
  parameter int CAPACITY = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rmu_pkg::S_TDATA_W-1:0]    s_tdata,   // [31:0] sample
  input  logic [0:0]                       s_tuser,   // [0] clear
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rmu_pkg::M_TDATA_W-1:0]    m_tdata,   // [32:0] median_doubled, [41:33] count
  output logic [0:0]                       m_tuser    // [0] overflow
);
  import rmu_pkg::*;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LEVELS = IDX_W;
  localparam int WAIT_W = $clog2(LEVELS + 2);

  rmu_state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_eff;
  logic [CNT_W-1:0]  count_new;
  logic [CNT_W-1:0]  half;
  logic [IDX_W-1:0]  lo_idx;
  logic [IDX_W-1:0]  hi_idx;
  logic [WAIT_W-1:0] wait_cnt;
  logic              ovf;
  logic              ovf_r;
  logic              in_xfer;
  logic              load_out;
  logic              tree_done;
  logic signed [SAMPLE_W-1:0]   x;
  logic [CNT_W+COUNT_W-1:0]     count_ext;
  logic signed [MEDIAN_W-1:0]   median;
  logic [2*SAMPLE_W-1:0]        root;

  logic                       gt_chain    [CAPACITY+1];
  logic signed [SAMPLE_W-1:0] value_chain [CAPACITY+1];
  logic [2*SAMPLE_W-1:0]      leaf        [CAPACITY];

  assign x       = s_tdata[SAMPLE_W-1:0];
  assign in_xfer = s_tvalid && s_tready;

  // Fill level after the optional clear, and after the insert
  assign count_eff = s_tuser[0] ? '0 : count;
  assign ovf       = (count_eff == CNT_W'(CAPACITY));
  assign count_new = ovf ? count_eff : count_eff + CNT_W'(1);
  assign half      = count_new >> 1;

  // Control sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = ST_WAIT;
      ST_WAIT: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control sequencer: outputs
  always_comb begin
    s_tready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = !rst;
      ST_WAIT: load_out = tree_done && (!m_tvalid || m_tready);
      default: ;
    endcase
  end

  assign tree_done = (wait_cnt == WAIT_W'(LEVELS + 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      wait_cnt <= '0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        count    <= count_new;
        wait_cnt <= '0;
      end else if (state == ST_WAIT && !tree_done) begin
        wait_cnt <= wait_cnt + WAIT_W'(1);
      end
    end
  end

  // Middle positions of the new fill level
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ovf_r  <= ovf;
      hi_idx <= half[IDX_W-1:0];
      lo_idx <= count_new[0] ? half[IDX_W-1:0] : half[IDX_W-1:0] - IDX_W'(1);
    end
  end

  // Sorted row of cells
  assign gt_chain[0]    = 1'b0;
  assign value_chain[0] = x;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rmu_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .load       (in_xfer && !ovf),
      .x          (x),
      .fill       (count_eff),
      .left_gt    (gt_chain[i]),
      .left_value (value_chain[i]),
      .lo_idx     (lo_idx),
      .hi_idx     (hi_idx),
      .gt         (gt_chain[i+1]),
      .value      (value_chain[i+1]),
      .leaf       (leaf[i])
    );
  end

  // Median read-out
  rmu_or_tree #(
    .LEAVES (CAPACITY),
    .WIDTH  (2*SAMPLE_W)
  ) u_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (root)
  );

  assign median = MEDIAN_W'($signed(root[SAMPLE_W-1:0]))
                + MEDIAN_W'($signed(root[2*SAMPLE_W-1:SAMPLE_W]));
  assign count_ext = {{COUNT_W{1'b0}}, count};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata    <= {(M_TDATA_W - MEDIAN_W - COUNT_W)'(0),
                     count_ext[COUNT_W-1:0], median};
      m_tuser[0] <= ovf_r;
    end
  end

endmodule
